### rtl/core/resource_state_transition_tracker_top_assert.svh
// Assertion macros for the tracker; clk and arst_n are taken from the enclosing scope.
`ifndef RESOURCE_STATE_TRANSITION_TRACKER_TOP_ASSERT_SVH
`define RESOURCE_STATE_TRANSITION_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RSTT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker assertion failed");

// Next-cycle implication.
`define RSTT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker assertion failed");

`endif

### rtl/core/rstt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rstt_pkg;

	localparam logic [3:0] STATE_MAX = 4'd11;

	// actions
	localparam logic [1:0] ACT_DECL   = 2'd0;
	localparam logic [1:0] ACT_USE    = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_IGNORE = 2'd3;

	// item kinds after classification
	localparam logic [2:0] K_NOP   = 3'd0;
	localparam logic [2:0] K_DECL  = 3'd1;
	localparam logic [2:0] K_USE   = 3'd2;
	localparam logic [2:0] K_CLEAR = 3'd3;
	localparam logic [2:0] K_ERR   = 3'd4;

	// result status
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_TRANS   = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_UNDECL  = 3'd3;
	localparam logic [2:0] ST_MIXED   = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  status;
		logic [5:0]  pass;
		logic [5:0]  res;
		logic [3:0]  acc;
		logic        whole;
		logic [15:0] sub;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  pass;
		logic [5:0]  res;
		logic        whole;
		logic [15:0] sub;
		logic [3:0]  from_st;
		logic [3:0]  after;
		logic        last;
	} rec_t;

	function automatic rec_t mk_rec(input logic [2:0] status, input logic [5:0] pass,
		input logic [5:0] res, input logic whole, input logic [15:0] sub,
		input logic [3:0] from_st, input logic [3:0] after, input logic last);
		rec_t r;
		r.status  = status;
		r.pass    = pass;
		r.res     = res;
		r.whole   = whole;
		r.sub     = sub;
		r.from_st = from_st;
		r.after   = after;
		r.last    = last;
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/rstt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rstt_front #(
	parameter int MAX_RESOURCES    = 64,
	parameter int MAX_PASSES       = 64,
	parameter int SUBRESOURCE_BITS = 16
) (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [39:0]   s_tdata,
	input  wire logic [1:0]    s_tuser,
	input  wire logic          q_full,
	output logic               q_push,
	output rstt_pkg::item_t    q_item
);
	import rstt_pkg::*;

	localparam int SBE = (SUBRESOURCE_BITS < 16) ? SUBRESOURCE_BITS : 16;
	localparam logic [15:0] SUB_MASK = 16'((32'h1 << SBE) - 32'h1);

	logic [5:0]  pass;
	logic [5:0]  res;
	logic [3:0]  acc;
	logic        whole;
	logic [15:0] sub;
	logic        acc_ok;
	logic        res_ok;
	logic        pass_ok;

	assign pass  = s_tdata[5:0];
	assign res   = s_tdata[11:6];
	assign acc   = s_tdata[15:12];
	assign whole = s_tdata[16];
	assign sub   = s_tdata[32:17] & SUB_MASK;

	assign acc_ok  = (acc != 4'd0) && (acc <= STATE_MAX);
	assign res_ok  = 32'(res) < MAX_RESOURCES;
	assign pass_ok = 32'(pass) < MAX_PASSES;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item        = '0;
		q_item.pass   = pass;
		q_item.res    = res;
		q_item.acc    = acc;
		q_item.whole  = whole;
		q_item.sub    = sub;
		q_item.kind   = K_NOP;
		q_item.status = ST_NONE;
		case (s_tuser)
			ACT_DECL: begin
				// out-of-range declares are dropped; bad states declare as unknown
				if (res_ok) q_item.kind = K_DECL;
				if (acc > STATE_MAX) q_item.acc = 4'd0;
			end
			ACT_USE: begin
				if (!acc_ok) begin
					q_item.kind   = K_ERR;
					q_item.status = ST_UNKNOWN;
				end else if (!res_ok || !pass_ok) begin
					q_item.kind   = K_ERR;
					q_item.status = ST_UNDECL;
				end else begin
					q_item.kind = K_USE;
				end
			end
			ACT_CLEAR: q_item.kind = K_CLEAR;
			default: q_item.kind = K_NOP;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/rstt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rstt_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rstt_pkg::item_t push_item,
	output logic                 full,
	output logic                 valid,
	output rstt_pkg::item_t      item,
	input  wire logic            pop
);
	import rstt_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

### rtl/core/rstt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rstt_back #(
	parameter int MAX_RESOURCES    = 64,
	parameter int MAX_EXCEPTIONS   = 8,
	parameter int SUBRESOURCE_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire rstt_pkg::item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rstt_pkg::rec_t       out_rec
);
	import rstt_pkg::*;

	localparam int RES_DEPTH = (MAX_RESOURCES < 64) ? MAX_RESOURCES : 64;
	localparam int RW  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int SW  = (MAX_EXCEPTIONS > 1) ? $clog2(MAX_EXCEPTIONS) : 1;
	localparam int CW  = $clog2(MAX_EXCEPTIONS + 1);
	localparam int SBE = (SUBRESOURCE_BITS < 16) ? SUBRESOURCE_BITS : 16;
	localparam int EW  = SBE + 4;
	localparam int XD  = RES_DEPTH << SW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HDR  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_LAST = 3'd5;
	localparam logic [2:0] S_SR   = 3'd6;
	localparam logic [2:0] S_SW   = 3'd7;

	logic [3:0]    ws_mem  [RES_DEPTH];
	logic [CW-1:0] cnt_mem [RES_DEPTH];
	logic [EW-1:0] exc_mem [XD];

	logic [2:0]     st_q, st_d;
	item_t          it_q;
	logic [3:0]     ws_rd_q;
	logic [CW-1:0]  cnt_rd_q;
	logic [EW-1:0]  exc_rd_q;
	logic [CW-1:0]  idx_q, idx_d;
	logic [CW-1:0]  idx_m1;
	logic [SW-1:0]  fidx_q, fidx_d;
	logic [3:0]     fst_q, fst_d;
	logic           fnd_q, fnd_d;
	rec_t           pend_q, pend_d;
	logic           pend_v_q, pend_v_d;
	logic [RES_DEPTH-1:0] decl_q;
	logic           decl_set, decl_clr;
	logic           out_v_q;
	rec_t           out_q;

	logic           ofree;
	logic           push;
	rec_t           push_rec;
	rec_t           stat_rec;
	logic           hdr_re;
	logic           ws_we;
	logic           cnt_we;
	logic [CW-1:0]  cnt_wd;
	logic           exc_we;
	logic [RW+SW-1:0] exc_wa;
	logic [EW-1:0]  exc_wd;
	logic           exc_re;
	logic [RW+SW-1:0] exc_ra;
	logic [RW-1:0]  ridx;
	logic [RW-1:0]  qidx;
	logic [SBE-1:0] esub;
	logic [3:0]     est;
	logic [3:0]     prior_st;
	logic           etr;
	logic           wtr;

	assign ridx   = it_q.res[RW-1:0];
	assign qidx   = q_item.res[RW-1:0];
	assign esub   = exc_rd_q[EW-1:4];
	assign est    = exc_rd_q[3:0];
	assign idx_m1 = idx_q - 1'b1;
	assign ofree  = !out_v_q || out_ready;
	assign etr    = (est != 4'd0) && (est != it_q.acc);
	assign wtr    = (ws_rd_q != 4'd0) && (ws_rd_q != it_q.acc);
	assign prior_st = fnd_q ? fst_q : ws_rd_q;
	assign stat_rec = mk_rec(ST_NONE, it_q.pass, it_q.res, it_q.whole,
		it_q.whole ? 16'd0 : it_q.sub, 4'd0, 4'd0, 1'b1);

	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		fidx_d   = fidx_q;
		fst_d    = fst_q;
		fnd_d    = fnd_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		push     = 1'b0;
		push_rec = stat_rec;
		q_pop    = 1'b0;
		hdr_re   = 1'b0;
		ws_we    = 1'b0;
		cnt_we   = 1'b0;
		cnt_wd   = '0;
		exc_we   = 1'b0;
		exc_wa   = {ridx, idx_q[SW-1:0]};
		exc_wd   = {it_q.sub[SBE-1:0], it_q.acc};
		exc_re   = 1'b0;
		exc_ra   = {ridx, idx_q[SW-1:0]};
		decl_set = 1'b0;
		decl_clr = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					hdr_re = 1'b1;
					st_d   = S_HDR;
				end
			end
			S_HDR: begin
				if (ofree) begin
					st_d = S_IDLE;
					case (it_q.kind)
						K_DECL: begin
							push = 1'b1;
							if (!decl_q[ridx]) begin
								decl_set = 1'b1;
								ws_we    = 1'b1;
								cnt_we   = 1'b1;
							end
						end
						K_CLEAR: begin
							push     = 1'b1;
							decl_clr = 1'b1;
						end
						K_ERR: begin
							push            = 1'b1;
							push_rec.status = it_q.status;
						end
						K_USE: begin
							if (!decl_q[ridx]) begin
								push            = 1'b1;
								push_rec.status = ST_UNDECL;
							end else if (it_q.whole && (cnt_rd_q != '0) && wtr) begin
								push            = 1'b1;
								push_rec.status = ST_MIXED;
							end else begin
								idx_d    = '0;
								pend_v_d = 1'b0;
								fnd_d    = 1'b0;
								st_d     = S_RD;
							end
						end
						default: push = 1'b1;
					endcase
				end
			end
			S_RD: begin
				if (idx_q == cnt_rd_q) begin
					st_d = S_FIN;
				end else begin
					exc_re = 1'b1;
					st_d   = S_EV;
				end
			end
			S_EV: begin
				if (it_q.whole) begin
					// flush: hold one record back so the last one can be marked
					if (!(etr && pend_v_q && !ofree)) begin
						if (etr) begin
							if (pend_v_q) begin
								push     = 1'b1;
								push_rec = pend_q;
							end
							pend_d = mk_rec(ST_TRANS, it_q.pass, it_q.res, 1'b0,
								16'(esub), est, it_q.acc, 1'b0);
							pend_v_d = 1'b1;
						end
						idx_d = idx_q + 1'b1;
						st_d  = S_RD;
					end
				end else if (esub == it_q.sub[SBE-1:0]) begin
					fnd_d  = 1'b1;
					fidx_d = idx_q[SW-1:0];
					fst_d  = est;
					st_d   = S_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
					st_d  = S_RD;
				end
			end
			S_FIN: begin
				if (ofree) begin
					if (it_q.whole) begin
						ws_we  = 1'b1;
						cnt_we = 1'b1;
						if (wtr) begin
							if (pend_v_q) begin
								push     = 1'b1;
								push_rec = pend_q;
							end
							pend_d = mk_rec(ST_TRANS, it_q.pass, it_q.res, 1'b1, 16'd0,
								ws_rd_q, it_q.acc, 1'b0);
							pend_v_d = 1'b1;
						end
						st_d = S_LAST;
					end else if (!fnd_q && (cnt_rd_q == CW'(MAX_EXCEPTIONS))
						&& (prior_st != it_q.acc)) begin
						push            = 1'b1;
						push_rec.status = ST_FULL;
						st_d            = S_IDLE;
					end else begin
						push = 1'b1;
						if ((prior_st != 4'd0) && (prior_st != it_q.acc))
							push_rec = mk_rec(ST_TRANS, it_q.pass, it_q.res, 1'b0,
								it_q.sub, prior_st, it_q.acc, 1'b1);
						st_d = S_IDLE;
						if (fnd_q) begin
							exc_we = 1'b1;
							exc_wa = {ridx, fidx_q};
							if (it_q.acc == ws_rd_q) begin
								// back to whole state: drop entry, close the gap
								cnt_we = 1'b1;
								cnt_wd = cnt_rd_q - 1'b1;
								idx_d  = CW'(fidx_q) + 1'b1;
								st_d   = S_SR;
							end
						end else if (prior_st != it_q.acc) begin
							exc_we = 1'b1;
							exc_wa = {ridx, cnt_rd_q[SW-1:0]};
							cnt_we = 1'b1;
							cnt_wd = cnt_rd_q + 1'b1;
						end
					end
				end
			end
			S_LAST: begin
				if (ofree) begin
					push = 1'b1;
					if (pend_v_q) begin
						push_rec      = pend_q;
						push_rec.last = 1'b1;
					end
					st_d = S_IDLE;
				end
			end
			S_SR: begin
				if (idx_q == cnt_rd_q) begin
					st_d = S_IDLE;
				end else begin
					exc_re = 1'b1;
					st_d   = S_SW;
				end
			end
			S_SW: begin
				exc_we = 1'b1;
				exc_wa = {ridx, idx_m1[SW-1:0]};
				exc_wd = exc_rd_q;
				idx_d  = idx_q + 1'b1;
				st_d   = S_SR;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ws_we) ws_mem[ridx] <= it_q.acc;
		if (cnt_we) cnt_mem[ridx] <= cnt_wd;
		if (hdr_re) begin
			ws_rd_q  <= ws_mem[qidx];
			cnt_rd_q <= cnt_mem[qidx];
		end
	end

	always_ff @(posedge clk) begin
		if (exc_we) exc_mem[exc_wa] <= exc_wd;
		if (exc_re) exc_rd_q <= exc_mem[exc_ra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_item;
		idx_q  <= idx_d;
		fidx_q <= fidx_d;
		fst_q  <= fst_d;
		fnd_q  <= fnd_d;
		pend_q <= pend_d;
		if (push) out_q <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			pend_v_q <= 1'b0;
			decl_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			pend_v_q <= pend_v_d;
			if (decl_clr) decl_q <= '0;
			else if (decl_set) decl_q[ridx] <= 1'b1;
			if (push) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_rec   = out_q;

endmodule
`default_nettype wire

### rtl/core/resource_state_transition_tracker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Resource access-state tracker. Words on the slave side declare, use or clear
// resources; each word yields one or more result words on the master side, the
// final one marked by m_tlast. A front classifier checks state, resource and
// pass ranges and drops the word into a two-word queue, so the next word is
// taken while the back sequencer works. The sequencer handles one word at a
// time: declare, clear and error words are answered from the header state; a
// use walks the exception slots through the single read port of the exception
// memory (up to MAX_EXCEPTIONS), and a whole use adds a step to mark its last
// word. Removing an exception moves the slots behind it down to close the gap.
// A result waiting on m_tready stalls the sequencer only when it has a further
// word to hand over. No clearing pass is needed after reset: declared bits are
// flip-flops and gate every state read.
module resource_state_transition_tracker_top #(
	parameter int MAX_RESOURCES    = 64,
	parameter int MAX_EXCEPTIONS   = 8,
	parameter int MAX_PASSES       = 64,
	parameter int SUBRESOURCE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pass_index[5:0], resource_index[11:6], access_state[15:12],
	// whole_resource[16], subresource_id[32:17], zero fill
	input  wire logic [39:0] s_tdata,
	// action[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_pass[5:0], out_resource[11:6], out_whole[12], out_subresource[28:13],
	// before_state[32:29], after_state[36:33], zero fill
	output logic [39:0]      m_tdata,
	// status[2:0]
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);
	import rstt_pkg::*;
	`include "resource_state_transition_tracker_top_assert.svh"

	logic  q_full;
	logic  q_push;
	item_t q_in;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;
	rec_t  rec;

	rstt_front #(
		.MAX_RESOURCES(MAX_RESOURCES),
		.MAX_PASSES(MAX_PASSES),
		.SUBRESOURCE_BITS(SUBRESOURCE_BITS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(q_in)
	);

	rstt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(q_in),
		.full(q_full),
		.valid(q_valid),
		.item(q_item),
		.pop(q_pop)
	);

	rstt_back #(
		.MAX_RESOURCES(MAX_RESOURCES),
		.MAX_EXCEPTIONS(MAX_EXCEPTIONS),
		.SUBRESOURCE_BITS(SUBRESOURCE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rec(rec)
	);

	assign m_tdata = {3'b000, rec.after, rec.from_st, rec.sub, rec.whole, rec.res, rec.pass};
	assign m_tuser = rec.status;
	assign m_tlast = rec.last;

	// back never pops an empty queue
	`RSTT_ASSERT_IMP(a_pop_valid, q_pop, q_valid)
	// an accepted word is queued by the next edge
	`RSTT_ASSERT_NXT(a_push_seen, s_tvalid && s_tready, q_valid)
	// a transition word always changes a known state
	`RSTT_ASSERT_IMP(a_trans_real, m_tvalid && (m_tuser == ST_TRANS),
		(m_tdata[32:29] != 4'd0) && (m_tdata[32:29] != m_tdata[36:33]))

endmodule
`default_nettype wire
